/* hw/rtl/fgb_pkg.sv */
// Shared types, constants and helper functions for the font glyph blitter.
// Holds the microcode program of the sequencer and the control/status structs.
// No dependencies.
package fgb_pkg;

  localparam int unsigned FONT_STORE_BYTES = 8192;
  localparam int unsigned MAX_GLYPH_ROWS   = 32;
  localparam int unsigned MAX_ROW_BYTES    = 2;

  localparam int unsigned STORE_AW = $clog2(FONT_STORE_BYTES);
  localparam int unsigned ROW_W    = $clog2(MAX_GLYPH_ROWS);
  localparam int unsigned BASE_W   = 15;
  localparam int unsigned IDX_W    = 21;
  localparam int unsigned PC_W     = 3;

  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] RED_MAX    = 8'd31;
  localparam logic [7:0] GREEN_MAX  = 8'd63;
  localparam logic [7:0] BLUE_MAX   = 8'd31;

  typedef enum logic [2:0] {
    REG_GLYPH_WIDTH,
    REG_GLYPH_HEIGHT,
    REG_LINE_PIXELS,
    REG_COLOR_RED,
    REG_COLOR_GREEN,
    REG_COLOR_BLUE
  } reg_idx_t;

  typedef struct packed {
    logic [4:0]  glyph_width;
    logic [5:0]  glyph_height;
    logic [10:0] line_pixels;
    logic [7:0]  color_red;
    logic [7:0]  color_green;
    logic [7:0]  color_blue;
  } cfg_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_DRAW,
    COND_BAD,
    COND_BUSY
  } cond_t;

  typedef struct packed {
    logic            in_rdy;
    logic            setup;
    logic            init;
    logic            rd;
    logic            emit;
    cond_t           cond;
    logic [PC_W-1:0] jmp;
    logic [PC_W-1:0] nxt;
  } ctl_t;

  typedef struct packed {
    logic no_draw;
    logic bad;
    logic busy;
  } stat_t;

  localparam logic [PC_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] STEP_SETUP = 3'd1;
  localparam logic [PC_W-1:0] STEP_CHECK = 3'd2;
  localparam logic [PC_W-1:0] STEP_READ  = 3'd3;
  localparam logic [PC_W-1:0] STEP_EMIT  = 3'd4;

  // Control store. A word jumps to jmp when its condition holds, else goes to nxt.
  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t w;
    w = '{in_rdy: 1'b0, setup: 1'b0, init: 1'b0, rd: 1'b0, emit: 1'b0,
          cond: COND_NEVER, jmp: STEP_IDLE, nxt: STEP_IDLE};
    unique case (pc)
      STEP_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond   = COND_NO_DRAW;
        w.jmp    = STEP_IDLE;
        w.nxt    = STEP_SETUP;
      end
      STEP_SETUP: begin
        w.setup = 1'b1;
        w.nxt   = STEP_CHECK;
      end
      STEP_CHECK: begin
        w.init = 1'b1;
        w.cond = COND_BAD;
        w.jmp  = STEP_IDLE;
        w.nxt  = STEP_READ;
      end
      STEP_READ: begin
        w.rd  = 1'b1;
        w.nxt = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.cond = COND_BUSY;
        w.jmp  = STEP_EMIT;
        w.nxt  = STEP_IDLE;
      end
      default: begin
        w.nxt = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // Byte msb is the leftmost pixel, which is mask bit 0.
  function automatic logic [7:0] flip8(input logic [7:0] b);
    logic [7:0] r;
    for (int n = 0; n < 8; n++) begin
      r[n] = b[7-n];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/fgb_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module fgb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/fgb_seq.sv */
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on fgb_pkg.
module fgb_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  fgb_pkg::stat_t stat,
  output fgb_pkg::ctl_t  ctl
);

  logic [fgb_pkg::PC_W-1:0] pc_r;
  logic [fgb_pkg::PC_W-1:0] pc_nxt;
  logic                     take;

  assign ctl = fgb_pkg::ucode(pc_r);

  always_comb begin
    case (ctl.cond)
      fgb_pkg::COND_NO_DRAW: take = stat.no_draw;
      fgb_pkg::COND_BAD:     take = stat.bad;
      fgb_pkg::COND_BUSY:    take = stat.busy;
      default:               take = 1'b0;
    endcase
    pc_nxt = take ? ctl.jmp : ctl.nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= fgb_pkg::STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* hw/rtl/fgb_dp.sv */
// Datapath: item capture, glyph geometry, address and index walkers, font store
// and the output register. Driven by the control word of fgb_seq.
// Depends on fgb_pkg and fgb_ram.
module fgb_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fgb_pkg::ctl_t                 ctl,
  output fgb_pkg::stat_t                stat,
  input  fgb_pkg::cfg_t                 cfg,
  input  logic                          in_tvalid,
  input  logic                          in_req_type,
  input  logic [12:0]                   store_addr,
  input  logic [7:0]                    store_byte,
  input  logic [7:0]                    char_code,
  input  logic [9:0]                    pos_x,
  input  logic [9:0]                    pos_y,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [fgb_pkg::IDX_W-1:0]     pixel_index,
  output logic [7:0]                    write_mask,
  output logic [15:0]                   pixel_color,
  output logic                          last
);

  localparam int unsigned AW = fgb_pkg::STORE_AW;
  localparam int unsigned BW = fgb_pkg::BASE_W;
  localparam int unsigned IW = fgb_pkg::IDX_W;
  localparam int unsigned RW = fgb_pkg::ROW_W;

  // Captured draw item.
  logic [7:0]  code_r;
  logic [9:0]  px_r;
  logic [9:0]  py_r;

  // Glyph geometry, set in the setup step.
  logic          two_col_r;
  logic [5:0]    h_r;
  logic [6:0]    spacing_r;
  logic [BW-1:0] base_r;
  logic [IW-1:0] pylp_r;
  logic [15:0]   color_r;
  logic          bad_r;

  // Walk state.
  logic [RW-1:0] i_r;
  logic          k_r;
  logic [AW-1:0] addr_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] start_r;

  // Output register.
  logic          out_valid_r;
  logic [IW-1:0] out_idx_r;
  logic [7:0]    out_mask_r;
  logic [15:0]   out_color_r;
  logic          out_last_r;

  logic          in_acc;
  logic          load_we;
  logic [4:0]    w_cap;
  logic [5:0]    h_cap;
  logic          two_col;
  logic [2:0]    col_bytes;
  logic [3:0]    units;
  logic [6:0]    spacing;
  logic [7:0]    code_off;
  logic [BW-1:0] base_prod;
  logic [IW-1:0] pylp_prod;
  logic          bad;
  logic [7:0]    red_s;
  logic [7:0]    green_s;
  logic [7:0]    blue_s;
  logic [BW:0]   span_end;
  logic          over;
  logic [IW-1:0] start_sum;
  logic          out_free;
  logic          fire;
  logic          last_i;
  logic          last_k;
  logic          last_byte;
  logic [AW-1:0] addr_nxt;
  logic [IW-1:0] idx_nxt;
  logic [RW-1:0] i_nxt;
  logic          k_nxt;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign in_acc  = ctl.in_rdy & in_tvalid;
  assign load_we = in_acc & !in_req_type &
                   (32'(store_addr) < 32'(fgb_pkg::FONT_STORE_BYTES));

  // Geometry from the registers and the captured code.
  always_comb begin
    w_cap = (32'(cfg.glyph_width) > 32'(fgb_pkg::MAX_ROW_BYTES * 8)) ?
            5'(fgb_pkg::MAX_ROW_BYTES * 8) : cfg.glyph_width;
    h_cap = (32'(cfg.glyph_height) > 32'(fgb_pkg::MAX_GLYPH_ROWS)) ?
            6'(fgb_pkg::MAX_GLYPH_ROWS) : cfg.glyph_height;
    two_col   = w_cap > 5'd8;
    col_bytes = 3'(({1'b0, h_cap} + 7'd7) >> 3);
    units     = two_col ? {col_bytes, 1'b0} : {1'b0, col_bytes};
    spacing   = {units, 3'b000};
    code_off  = code_r - fgb_pkg::FIRST_CODE;
    base_prod = BW'(spacing) * BW'(code_off);
    pylp_prod = IW'(py_r) * IW'(cfg.line_pixels);
    bad       = (w_cap == 5'd0) | (h_cap == 6'd0) | (code_r < fgb_pkg::FIRST_CODE);
    red_s     = (cfg.color_red   > fgb_pkg::RED_MAX)   ? fgb_pkg::RED_MAX   : cfg.color_red;
    green_s   = (cfg.color_green > fgb_pkg::GREEN_MAX) ? fgb_pkg::GREEN_MAX : cfg.color_green;
    blue_s    = (cfg.color_blue  > fgb_pkg::BLUE_MAX)  ? fgb_pkg::BLUE_MAX  : cfg.color_blue;
    span_end  = {1'b0, base_r} + (BW+1)'(spacing_r);
    over      = 32'(span_end) > 32'(fgb_pkg::FONT_STORE_BYTES);
    start_sum = pylp_r + IW'(px_r);
  end

  // Walk: row i inner, byte column k outer.
  always_comb begin
    out_free  = !out_valid_r | out_tready;
    fire      = ctl.emit & out_free;
    last_i    = (6'(i_r) == (h_r - 6'd1));
    last_k    = !two_col_r | k_r;
    last_byte = last_i & last_k;
    if (last_i) begin
      i_nxt    = '0;
      k_nxt    = 1'b1;
      addr_nxt = AW'(base_r) + AW'(1);
      idx_nxt  = start_r + IW'(8);
    end else begin
      i_nxt    = i_r + RW'(1);
      k_nxt    = k_r;
      addr_nxt = addr_r + (two_col_r ? AW'(2) : AW'(1));
      idx_nxt  = idx_r + IW'(cfg.line_pixels);
    end
    ram_re    = ctl.rd | (fire & !last_byte);
    ram_raddr = ctl.emit ? addr_nxt : addr_r;
  end

  assign stat.no_draw = !(in_acc & in_req_type);
  assign stat.bad     = bad_r | over;
  assign stat.busy    = !(fire & last_byte);

  fgb_ram #(
    .WIDTH (8),
    .DEPTH (fgb_pkg::FONT_STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(store_addr)),
    .wdata (store_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      code_r <= char_code;
      px_r   <= pos_x;
      py_r   <= pos_y;
    end
    if (ctl.setup) begin
      two_col_r <= two_col;
      h_r       <= h_cap;
      spacing_r <= spacing;
      base_r    <= base_prod;
      pylp_r    <= pylp_prod;
      color_r   <= {red_s[4:0], green_s[5:0], blue_s[4:0]};
      bad_r     <= bad;
    end
    if (ctl.init) begin
      i_r     <= '0;
      k_r     <= 1'b0;
      addr_r  <= AW'(base_r);
      idx_r   <= start_sum;
      start_r <= start_sum;
    end else if (fire) begin
      i_r    <= i_nxt;
      k_r    <= k_nxt;
      addr_r <= addr_nxt;
      idx_r  <= idx_nxt;
    end
    if (fire) begin
      out_idx_r   <= idx_r;
      out_mask_r  <= fgb_pkg::flip8(ram_rdata);
      out_color_r <= color_r;
      out_last_r  <= last_byte;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign pixel_index = out_idx_r;
  assign write_mask  = out_mask_r;
  assign pixel_color = out_color_r;
  assign last        = out_last_r;

  // The final write of a character ends the walk; nothing follows it at once.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && last_byte) |=> !fire)
    else $error("write issued right after the final write of a character");

  // Every store read stays inside the store.
  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (32'(ram_raddr) < 32'(fgb_pkg::FONT_STORE_BYTES)))
    else $error("font store read out of range");

  // The row counter never runs past the glyph height while writing.
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> (6'(i_r) < h_r))
    else $error("row counter beyond glyph height");

  // A new item is never taken while a walk is in progress.
  a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit && !(fire && last_byte)) |=> !ctl.in_rdy)
    else $error("input accepted during a glyph walk");

endmodule

/* hw/rtl/font_glyph_blitter.sv */
// Top level of the font glyph blitter: configuration registers, APB-style port,
// sequencer and datapath. Depends on fgb_pkg, fgb_seq, fgb_dp and fgb_ram.
//
// Usage. The input stream carries two kinds of transaction, chosen by in_tuser.
// A load (in_tuser 0) writes store_byte into the font store at store_addr and
// produces nothing. A draw (in_tuser 1) names a character code and a pixel
// position; the block then emits one masked 8-pixel write per glyph byte on
// the output stream, byte column outer and glyph row inner, with out_tlast on
// the final write. Codes below 32, zero width or height, and glyphs that do
// not lie wholly inside the store produce no writes.
// Sequence: a draw is accepted in the idle step, then passes through setup, the
// range check and the first store read before the emit step, where its writes
// are registered. There one write leaves per cycle while out_tready is high,
// since the next store read is issued as each write is registered. A rejected
// draw returns to idle from the range check. The sequencer's five-step program
// orders these steps.
// A stalled receiver holds the output register and the walk freezes in place.
// Reset (synchronous, rst_n low) returns the sequencer to idle, empties the
// output register and restores the register defaults; the font store is not
// cleared and must be loaded before it is drawn from.
module font_glyph_blitter (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream. tdata from bit 0: store_addr[12:0], store_byte[20:13],
  // char_code[28:21], pos_x[38:29], pos_y[48:39], zero fill [55:49].
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,
  // tuser: req_type (0 load, 1 draw).
  input  logic        in_tuser,
  // Output stream. tdata from bit 0: pixel_index[20:0], write_mask[28:21],
  // pixel_color[44:29], zero fill [47:45].
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic        out_tlast,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  fgb_pkg::cfg_t     cfg_r;
  fgb_pkg::ctl_t     ctl;
  fgb_pkg::stat_t    stat;
  fgb_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;
  logic [20:0]       pixel_index;
  logic [7:0]        write_mask;
  logic [15:0]       pixel_color;

  // Registers sit at byte address 4*index; the two low address bits are ignored.
  assign reg_idx    = fgb_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.glyph_width  <= 5'd8;
      cfg_r.glyph_height <= 6'd16;
      cfg_r.line_pixels  <= 11'd240;
      cfg_r.color_red    <= 8'd0;
      cfg_r.color_green  <= 8'd0;
      cfg_r.color_blue   <= 8'd0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        fgb_pkg::REG_GLYPH_WIDTH:  cfg_r.glyph_width  <= cfg_pwdata[4:0];
        fgb_pkg::REG_GLYPH_HEIGHT: cfg_r.glyph_height <= cfg_pwdata[5:0];
        fgb_pkg::REG_LINE_PIXELS:  cfg_r.line_pixels  <= cfg_pwdata[10:0];
        fgb_pkg::REG_COLOR_RED:    cfg_r.color_red    <= cfg_pwdata[7:0];
        fgb_pkg::REG_COLOR_GREEN:  cfg_r.color_green  <= cfg_pwdata[7:0];
        fgb_pkg::REG_COLOR_BLUE:   cfg_r.color_blue   <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Read-back of the register selected by the address.
  always_comb begin
    unique case (reg_idx)
      fgb_pkg::REG_GLYPH_WIDTH:  cfg_prdata = 32'(cfg_r.glyph_width);
      fgb_pkg::REG_GLYPH_HEIGHT: cfg_prdata = 32'(cfg_r.glyph_height);
      fgb_pkg::REG_LINE_PIXELS:  cfg_prdata = 32'(cfg_r.line_pixels);
      fgb_pkg::REG_COLOR_RED:    cfg_prdata = 32'(cfg_r.color_red);
      fgb_pkg::REG_COLOR_GREEN:  cfg_prdata = 32'(cfg_r.color_green);
      fgb_pkg::REG_COLOR_BLUE:   cfg_prdata = 32'(cfg_r.color_blue);
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  // Only the idle step of the program takes input transactions.
  assign in_tready = ctl.in_rdy;

  fgb_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  fgb_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .stat        (stat),
    .cfg         (cfg_r),
    .in_tvalid   (in_tvalid),
    .in_req_type (in_tuser),
    .store_addr  (in_tdata[12:0]),
    .store_byte  (in_tdata[20:13]),
    .char_code   (in_tdata[28:21]),
    .pos_x       (in_tdata[38:29]),
    .pos_y       (in_tdata[48:39]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .pixel_index (pixel_index),
    .write_mask  (write_mask),
    .pixel_color (pixel_color),
    .last        (out_tlast)
  );

  assign out_tdata = {3'b000, pixel_color, write_mask, pixel_index};

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the font glyph blitter: random and directed font loads
// and character draws, checked write by write. Depends on fgb_pkg and font_glyph_blitter.
`timescale 1ns / 100ps

module tb_top;

  // The block does not define a code for the kind of an input transaction, so the
  // testbench names its own: in_tuser low loads a font byte, high draws a character.
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_DRAW = 1'b1
  } req_kind_t;

  // One masked 8-pixel write as the block emits it on the output stream.
  typedef struct packed {
    logic [fgb_pkg::IDX_W-1:0] pixel_index;
    logic [7:0]                write_mask;
    logic [15:0]               pixel_color;
    logic                      last;
  } glyph_write_t;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned IDLE_PERCENT  = 28;
  localparam int unsigned REPORT_LIMIT  = 10;

  // The scoreboard keeps its own copy of the registers and of the font store. Each
  // accepted input transaction updates that copy or expands into the writes that a
  // draw must produce; each accepted output transaction is matched against the
  // oldest write still pending.
  class glyph_write_board;
    fgb_pkg::cfg_t regs;
    logic [7:0]    store [fgb_pkg::FONT_STORE_BYTES];
    bit            written [fgb_pkg::FONT_STORE_BYTES];
    glyph_write_t  pending [$];
    int unsigned   faults;
    int unsigned   reported;

    function new();
      regs = '{glyph_width: 5'd8, glyph_height: 6'd16, line_pixels: 11'd240,
               color_red: 8'd0, color_green: 8'd0, color_blue: 8'd0};
      faults   = 0;
      reported = 0;
    endfunction

    function void set_reg(input fgb_pkg::reg_idx_t idx, input logic [31:0] value);
      case (idx)
        fgb_pkg::REG_GLYPH_WIDTH:  regs.glyph_width  = value[4:0];
        fgb_pkg::REG_GLYPH_HEIGHT: regs.glyph_height = value[5:0];
        fgb_pkg::REG_LINE_PIXELS:  regs.line_pixels  = value[10:0];
        fgb_pkg::REG_COLOR_RED:    regs.color_red    = value[7:0];
        fgb_pkg::REG_COLOR_GREEN:  regs.color_green  = value[7:0];
        fgb_pkg::REG_COLOR_BLUE:   regs.color_blue   = value[7:0];
        default: ;
      endcase
    endfunction

    // Tells whether a draw of this code reads the store under the current settings,
    // and if so where its glyph starts, how many bytes a row has and how many rows
    // are walked. The bytes read are the contiguous span base .. base+row_bytes*rows-1.
    function bit glyph_span(input logic [7:0] code, output int unsigned base,
                            output int unsigned row_bytes, output int unsigned rows);
      int unsigned w;
      int unsigned h;
      int unsigned spacing;
      w = (regs.glyph_width > fgb_pkg::MAX_ROW_BYTES * 8) ?
          fgb_pkg::MAX_ROW_BYTES * 8 : regs.glyph_width;
      h = (regs.glyph_height > fgb_pkg::MAX_GLYPH_ROWS) ?
          fgb_pkg::MAX_GLYPH_ROWS : regs.glyph_height;
      base      = 0;
      row_bytes = 0;
      rows      = 0;
      if (w == 0 || h == 0 || code < fgb_pkg::FIRST_CODE) begin
        return 1'b0;
      end
      row_bytes = (w + 7) / 8;
      rows      = h;
      // A glyph always takes whole 8-row blocks of the store, even when the font
      // height is not a multiple of eight.
      spacing   = row_bytes * ((h + 7) / 8) * 8;
      base      = spacing * (code - fgb_pkg::FIRST_CODE);
      return (base + spacing <= fgb_pkg::FONT_STORE_BYTES);
    endfunction

    function void note_request(input req_kind_t kind, input logic [55:0] data);
      logic [12:0]  addr;
      logic [7:0]   code;
      logic [9:0]   pos_x;
      logic [9:0]   pos_y;
      logic [7:0]   red;
      logic [7:0]   green;
      logic [7:0]   blue;
      logic [7:0]   glyph_byte;
      int unsigned  base;
      int unsigned  row_bytes;
      int unsigned  rows;
      int unsigned  lin;
      glyph_write_t w;
      addr  = data[12:0];
      code  = data[28:21];
      pos_x = data[38:29];
      pos_y = data[48:39];
      if (kind == REQ_LOAD) begin
        store[addr]   = data[20:13];
        written[addr] = 1'b1;
        return;
      end
      if (!glyph_span(code, base, row_bytes, rows)) begin
        return;
      end
      red   = (regs.color_red > fgb_pkg::RED_MAX) ? fgb_pkg::RED_MAX : regs.color_red;
      green = (regs.color_green > fgb_pkg::GREEN_MAX) ? fgb_pkg::GREEN_MAX :
                                                        regs.color_green;
      blue  = (regs.color_blue > fgb_pkg::BLUE_MAX) ? fgb_pkg::BLUE_MAX : regs.color_blue;
      // Byte column outer, glyph row inner; the frame buffer index wraps at 2^21.
      for (int unsigned k = 0; k < row_bytes; k++) begin
        for (int unsigned i = 0; i < rows; i++) begin
          glyph_byte    = store[base + row_bytes * i + k];
          lin           = (pos_y + i) * regs.line_pixels + pos_x + 8 * k;
          w.pixel_index = lin[fgb_pkg::IDX_W-1:0];
          w.write_mask  = {<<{glyph_byte}};
          w.pixel_color = {red[4:0], green[5:0], blue[4:0]};
          w.last        = (k == row_bytes - 1) && (i == rows - 1);
          pending.push_back(w);
        end
      end
    endfunction

    function void check_write(input logic [47:0] data, input logic tlast);
      glyph_write_t seen;
      glyph_write_t want;
      seen = '{pixel_index: data[20:0], write_mask: data[28:21],
               pixel_color: data[44:29], last: tlast};
      if (pending.size() == 0) begin
        faults++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display("%0t: unexpected glyph write: index %0d mask %02h color %04h last %0b",
                   $realtime, seen.pixel_index, seen.write_mask, seen.pixel_color, seen.last);
        end
        return;
      end
      want = pending.pop_front();
      if (seen != want) begin
        faults++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display("%0t: glyph write mismatch: expected index %0d mask %02h color %04h last %0b",
                   $realtime, want.pixel_index, want.write_mask, want.pixel_color, want.last);
          $display("%0t:                       got      index %0d mask %02h color %04h last %0b",
                   $realtime, seen.pixel_index, seen.write_mask, seen.pixel_color, seen.last);
        end
      end
    endfunction

    function int unsigned pending_count();
      return pending.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // tdata from bit 0: store_addr[12:0], store_byte[20:13], char_code[28:21],
  // pos_x[38:29], pos_y[48:39], zero fill [55:49].
  logic [55:0] in_tdata;
  // tuser: req_type (0 load, 1 draw).
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // tdata from bit 0: pixel_index[20:0], write_mask[28:21], pixel_color[44:29],
  // zero fill [47:45].
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  glyph_write_board board = new();

  // While calm is set neither side of the stream idles, which gives one long
  // stretch of back-to-back transactions.
  bit          calm = 1'b0;
  int unsigned items_sent = 0;

  font_glyph_blitter i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // The receiver stalls IDLE_PERCENT percent of the time. Like every other
  // input it changes on the falling edge, so the block sees it settled at the
  // rising edge.
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Every output transaction is sampled at the rising edge where it completes.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_write(out_tdata, out_tlast);
    end
  end

  // Watchdog: the run is stuck once the quiet counter, which restarts at every
  // completed transaction on either stream, reaches STALL_LIMIT.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("font_glyph_blitter verification failed");
    $finish;
  end

  // Field packing of an input transaction. Fields that the kind does not use are
  // filled by the caller with noise, which the block has to ignore.
  function automatic logic [55:0] pack_item(input logic [12:0] addr, input logic [7:0] sbyte,
                                            input logic [7:0] code, input logic [9:0] pos_x,
                                            input logic [9:0] pos_y);
    return {7'd0, pos_y, pos_x, code, sbyte, addr};
  endfunction

  // Offers one input transaction, with random idle cycles ahead of it, and waits
  // for it to be accepted. tvalid is left high afterwards: the next call, or
  // wait_drained, decides at the next falling edge whether it drops.
  task automatic send_item(input req_kind_t kind, input logic [55:0] data);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do begin
      @(posedge clk);
    end while (!in_tready);
    board.note_request(kind, data);
    items_sent++;
  endtask

  task automatic load_byte(input logic [12:0] addr, input logic [7:0] value);
    send_item(REQ_LOAD, pack_item(addr, value, 8'($urandom), 10'($urandom), 10'($urandom)));
  endtask

  // A draw may only read store bytes that have been loaded, so any byte of the
  // glyph that was never written is loaded with random content first.
  task automatic draw_char(input logic [7:0] code, input logic [9:0] pos_x,
                           input logic [9:0] pos_y);
    int unsigned base;
    int unsigned row_bytes;
    int unsigned rows;
    if (board.glyph_span(code, base, row_bytes, rows)) begin
      for (int unsigned a = base; a < base + row_bytes * rows; a++) begin
        if (!board.written[a]) begin
          load_byte(13'(a), 8'($urandom));
        end
      end
    end
    send_item(REQ_DRAW, pack_item(13'($urandom), 8'($urandom), code, pos_x, pos_y));
  endtask

  // Stops offering input, waits for every pending write and then lets the block
  // finish any load or rejected draw that produces nothing.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.pending_count() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write: a setup cycle, then an access cycle that completes at
  // the rising edge where pready is high.
  task automatic write_reg(input fgb_pkg::reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_pready);
    board.set_reg(idx, value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_font(input int unsigned w, input int unsigned h, input int unsigned lp,
                          input int unsigned red, input int unsigned green,
                          input int unsigned blue);
    write_reg(fgb_pkg::REG_GLYPH_WIDTH, w);
    write_reg(fgb_pkg::REG_GLYPH_HEIGHT, h);
    write_reg(fgb_pkg::REG_LINE_PIXELS, lp);
    write_reg(fgb_pkg::REG_COLOR_RED, red);
    write_reg(fgb_pkg::REG_COLOR_GREEN, green);
    write_reg(fgb_pkg::REG_COLOR_BLUE, blue);
  endtask

  // Mostly small fonts so that glyph loads stay cheap, with occasional large and
  // out-of-range sizes, including zero and values that saturate.
  task automatic random_font();
    int unsigned w;
    int unsigned h;
    int unsigned lp;
    case ($urandom_range(19))
      0, 1, 2:    w = $urandom_range(9, 16);
      3, 4:       w = $urandom_range(0, 31);
      default:    w = $urandom_range(1, 8);
    endcase
    case ($urandom_range(19))
      0, 1, 2:    h = $urandom_range(13, 32);
      3, 4:       h = $urandom_range(0, 63);
      default:    h = $urandom_range(1, 12);
    endcase
    lp = $urandom_range(1) ? $urandom_range(1, 1024) : $urandom_range(0, 2047);
    set_font(w, h, lp, $urandom_range(255), $urandom_range(255), $urandom_range(255));
  endtask

  initial begin
    int unsigned pick;
    int unsigned target;
    int unsigned base;
    int unsigned row_bytes;
    int unsigned rows;
    logic [7:0]  code;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = REQ_LOAD;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // Directed part. A tiny font (one byte per row, two rows) keeps the loads
    // short. Full color levels saturate, and the widest line puts the index of
    // the bottom-right corner on the last entry of the frame buffer.
    set_font(5, 2, 2047, 255, 255, 255);
    load_byte(13'd0, 8'hFF);
    load_byte(13'd1, 8'h00);
    load_byte(13'd1784, 8'h80);
    load_byte(13'd1785, 8'h01);
    load_byte(13'd8191, 8'h5A);
    draw_char(8'd32, 10'd0, 10'd0);
    draw_char(8'd32, 10'd1023, 10'd1023);
    draw_char(8'd255, 10'd1023, 10'd0);
    // Codes below the first glyph draw nothing.
    draw_char(8'd0, 10'd0, 10'd1023);
    draw_char(8'd31, 10'd512, 10'd512);
    wait_drained();

    // Zero width, then zero height with a zero line length: nothing is drawn.
    set_font(0, 16, 240, 31, 63, 31);
    draw_char(8'd32, 10'd3, 10'd4);
    wait_drained();
    set_font(8, 0, 0, 32, 64, 32);
    draw_char(8'd32, 10'd3, 10'd4);
    wait_drained();

    // Oversized width saturates to two bytes per row, then oversized height
    // saturates to the tallest glyph.
    set_font(31, 1, 1024, 0, 0, 0);
    draw_char(8'd32, 10'd1020, 10'd5);
    wait_drained();
    set_font(8, 63, 1, 1, 2, 3);
    draw_char(8'd32, 10'd7, 10'd9);
    wait_drained();

    // With the largest glyph, code 160 is the first that lies beyond the end of the
    // store and must be dropped.
    set_font(16, 32, 240, 31, 0, 31);
    draw_char(8'd160, 10'd0, 10'd0);
    wait_drained();

    // Random part, one register setting per phase. Most traffic is a few draws of
    // a glyph, half the time after a fresh load of it; the rest is stray loads,
    // codes below the first glyph, arbitrary codes, and now and then a pause until
    // every pending write has left the block.
    for (int phase = 0; phase < 8; phase++) begin
      calm = (phase == 2);
      random_font();
      target = items_sent + 30;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          code = ($urandom_range(9) < 7) ? 8'($urandom_range(32, 40)) :
                                           8'($urandom_range(32, 255));
          if ($urandom_range(1) == 1 && board.glyph_span(code, base, row_bytes, rows)) begin
            for (int unsigned a = base; a < base + row_bytes * rows; a++) begin
              load_byte(13'(a), 8'($urandom));
            end
          end
          repeat ($urandom_range(1, 3)) draw_char(code, 10'($urandom), 10'($urandom));
        end else if (pick < 75) begin
          load_byte(13'($urandom), 8'($urandom));
        end else if (pick < 88) begin
          draw_char(8'($urandom_range(0, 31)), 10'($urandom), 10'($urandom));
        end else if (pick < 96) begin
          draw_char(8'($urandom), 10'($urandom), 10'($urandom));
        end else begin
          wait_drained();
        end
      end
      wait_drained();
    end
    calm = 1'b0;

    if (board.faults == 0 && board.pending_count() == 0) begin
      $display("font_glyph_blitter verification clean");
    end else begin
      $display("font_glyph_blitter verification failed");
    end
    $finish;
  end

endmodule
